[rtl/core/command_frame_receiver_core_defines.svh]
// ============================================================================
// Command frame receiver assertion macros
// Shared helpers for concurrent checks; they vanish in synthesis builds.
// ============================================================================
`ifndef COMMAND_FRAME_RECEIVER_CORE_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define CFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfr assertion failed");

// Next-cycle implication, checked outside reset.
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfr assertion failed");

`else

`define CFR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/cfr_pkg.sv]
// ============================================================================
// Command frame receiver package
// Frame constants, command codes and the decoded command type.
// ============================================================================
package cfr_pkg;

  // Largest payload length that a frame may announce.
  localparam int MAX_PAYLOAD = 5;
  // Bits for payload length and index, which run up to MAX_PAYLOAD.
  localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

  // Frame delimiters.
  localparam logic [7:0] HDR_BYTE = 8'hAA;
  localparam logic [7:0] TRL_BYTE = 8'h55;

  // Command bytes.
  localparam logic [7:0] CMD_START  = 8'h01;
  localparam logic [7:0] CMD_STOP   = 8'h03;
  localparam logic [7:0] CMD_MODE   = 8'h11;
  localparam logic [7:0] ARG_CONFIRM = 8'hFF;

  // Mode switch arguments.
  localparam logic [7:0] MODE_ARG_PRESS = 8'h01;
  localparam logic [7:0] MODE_ARG_IDLE  = 8'h02;
  localparam logic [7:0] MODE_ARG_BLOW  = 8'h03;

  // Detection mode codes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_PRESS = 2'd1;
  localparam logic [1:0] MODE_BLOW  = 2'd2;

  // Decoder result: state after the beat plus its one-beat pulses.
  typedef struct packed {
    logic [1:0] mode;
    logic       active;
    logic       clr_press;
    logic       clr_blow;
    logic       accepted;
  } cmd_t;

endpackage

[rtl/core/cfr_cmd_decode.sv]
// ============================================================================
// Command frame receiver command decoder
// Turns the first two payload bytes of a closed frame into mode and
// acquisition updates with their clear pulses.
// ============================================================================
module cfr_cmd_decode (
  input  logic          trailer_hit,
  input  logic [7:0]    cmd_byte,
  input  logic [7:0]    arg_byte,
  input  logic [1:0]    mode_cur,
  input  logic          active_cur,
  output cfr_pkg::cmd_t cmd
);

  // Known commands update state; anything else only flags the frame.
  always_comb begin
    cmd.mode      = mode_cur;
    cmd.active    = active_cur;
    cmd.clr_press = 1'b0;
    cmd.clr_blow  = 1'b0;
    cmd.accepted  = trailer_hit;
    if (trailer_hit) begin
      if (cmd_byte == cfr_pkg::CMD_START && arg_byte == cfr_pkg::ARG_CONFIRM) begin
        cmd.active    = 1'b1;
        cmd.clr_press = 1'b1;
        cmd.clr_blow  = 1'b1;
      end else if (cmd_byte == cfr_pkg::CMD_STOP && arg_byte == cfr_pkg::ARG_CONFIRM) begin
        cmd.active = 1'b0;
      end else if (cmd_byte == cfr_pkg::CMD_MODE) begin
        case (arg_byte)
          cfr_pkg::MODE_ARG_PRESS: begin
            cmd.mode     = cfr_pkg::MODE_PRESS;
            cmd.clr_blow = 1'b1;
          end
          cfr_pkg::MODE_ARG_IDLE: begin
            cmd.mode      = cfr_pkg::MODE_IDLE;
            cmd.clr_press = 1'b1;
            cmd.clr_blow  = 1'b1;
          end
          cfr_pkg::MODE_ARG_BLOW: begin
            cmd.mode      = cfr_pkg::MODE_BLOW;
            cmd.clr_press = 1'b1;
          end
          default: begin
            cmd.mode = mode_cur;
          end
        endcase
      end
    end
  end

endmodule

[rtl/core/command_frame_receiver_core.sv]
// ============================================================================
// Command frame receiver core
// Parses received bytes into header/length/payload/checksum/trailer frames
// and decodes start, stop and mode switch commands.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in_     | input     | in_valid/in_stall  | in_rx_byte
//  out_    | output    | out_valid/out_stall| mode, acquiring, clears, accepted
//
// Every accepted byte produces exactly one result beat in the next cycle.
// Unless stalled, a byte is taken every cycle; the running checksum keeps
// the per-byte work to one add and compare between the parser state and the
// result register. The input stalls only while a result beat is held and the
// output is stalled. Synchronous active-low reset returns the parser to waiting
// for a header, the mode to idle and acquisition to off.
//
`include "command_frame_receiver_core_defines.svh"

module command_frame_receiver_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_detect_mode,
  output logic       out_acquiring,
  output logic       out_clear_press_counts,
  output logic       out_clear_blow_counts,
  output logic       out_frame_accepted
);

  // Parser phases.
  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_LENGTH   = 3'd1;
  localparam logic [2:0] PH_PAYLOAD  = 3'd2;
  localparam logic [2:0] PH_CHECKSUM = 3'd3;
  localparam logic [2:0] PH_TRAILER  = 3'd4;

  localparam int IW = cfr_pkg::IDX_W;

  logic [2:0]    phase_r, phase_nxt;
  logic [IW-1:0] len_r, len_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] idx_inc;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    store0_r, store0_nxt;
  logic [7:0]    store1_r, store1_nxt;
  logic [1:0]    mode_r;
  logic          active_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_mode_r;
  logic          out_active_r;
  logic          out_clr_press_r;
  logic          out_clr_blow_r;
  logic          out_acc_r;

  logic          in_accept;
  logic          trailer_hit;
  cfr_pkg::cmd_t cmd;

  // Handshake: a held result only blocks input when it is stalled.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign idx_inc   = idx_r + IW'(1);

  // Parser next state for the beat on the input.
  always_comb begin
    phase_nxt  = phase_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    store0_nxt = store0_r;
    store1_nxt = store1_r;
    case (phase_r)
      PH_LENGTH: begin
        if (in_rx_byte > 8'(cfr_pkg::MAX_PAYLOAD)) begin
          phase_nxt = PH_HEADER;
        end else begin
          len_nxt   = in_rx_byte[IW-1:0];
          sum_nxt   = sum_r + in_rx_byte;
          idx_nxt   = '0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (idx_r == IW'(0)) begin
          store0_nxt = in_rx_byte;
        end
        if (idx_r == IW'(1)) begin
          store1_nxt = in_rx_byte;
        end
        if (idx_r < len_r) begin
          sum_nxt = sum_r + in_rx_byte;
        end
        idx_nxt = idx_inc;
        if (idx_inc >= len_r || idx_inc >= IW'(cfr_pkg::MAX_PAYLOAD)) begin
          phase_nxt = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        if (sum_r == in_rx_byte) begin
          phase_nxt = PH_TRAILER;
        end else begin
          phase_nxt = PH_HEADER;
          idx_nxt   = '0;
        end
      end
      PH_TRAILER: begin
        phase_nxt = PH_HEADER;
        idx_nxt   = '0;
      end
      default: begin
        phase_nxt = PH_HEADER;
        if (in_rx_byte == cfr_pkg::HDR_BYTE) begin
          phase_nxt = PH_LENGTH;
          idx_nxt   = '0;
          sum_nxt   = cfr_pkg::HDR_BYTE;
        end
      end
    endcase
  end

  // Command decode on a good trailer.
  assign trailer_hit = (phase_r == PH_TRAILER) && (in_rx_byte == cfr_pkg::TRL_BYTE);

  cfr_cmd_decode u_decode (
    .trailer_hit (trailer_hit),
    .cmd_byte    (store0_r),
    .arg_byte    (store1_r),
    .mode_cur    (mode_r),
    .active_cur  (active_r),
    .cmd         (cmd)
  );

  // Parser and command state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      len_r    <= '0;
      idx_r    <= '0;
      sum_r    <= '0;
      store0_r <= '0;
      store1_r <= '0;
      mode_r   <= cfr_pkg::MODE_IDLE;
      active_r <= 1'b0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      sum_r    <= sum_nxt;
      store0_r <= store0_nxt;
      store1_r <= store1_nxt;
      mode_r   <= cmd.mode;
      active_r <= cmd.active;
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_mode_r      <= cmd.mode;
      out_active_r    <= cmd.active;
      out_clr_press_r <= cmd.clr_press;
      out_clr_blow_r  <= cmd.clr_blow;
      out_acc_r       <= cmd.accepted;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_detect_mode        = out_mode_r;
  assign out_acquiring          = out_active_r;
  assign out_clear_press_counts = out_clr_press_r;
  assign out_clear_blow_counts  = out_clr_blow_r;
  assign out_frame_accepted     = out_acc_r;

  // Checks on parser and result logic.
  `CFR_ASSERT_IMPL(a_phase_legal, clk, rst_n, 1'b1, phase_r <= PH_TRAILER)
  `CFR_ASSERT_IMPL(a_idx_bound, clk, rst_n, 1'b1, idx_r <= IW'(cfr_pkg::MAX_PAYLOAD))
  `CFR_ASSERT_IMPL(a_clear_needs_frame, clk, rst_n, out_valid_r && (out_clr_press_r || out_clr_blow_r), out_acc_r)
  `CFR_ASSERT_NEXT(a_trailer_accepts, clk, rst_n, in_accept && trailer_hit, out_valid_r && out_acc_r)
  `CFR_ASSERT_IMPL(a_stall_needs_full, clk, rst_n, in_stall, out_valid_r)

endmodule
